// ----- rtl/crtp_pkg.sv -----
// shared codes, field widths and state type of the context region time profiler
package crtp_pkg;

    localparam int OP_W       = 3;
    localparam int OFFSET_W   = 20;
    localparam int STAMP_W    = 64;
    localparam int RIDX_W     = 10;
    localparam int CTX_W      = 32;
    localparam int COUNT_W    = 11;
    localparam int DEPTH_W    = 16;
    localparam int S_DATA_W   = 96;
    localparam int M_DATA_W   = 184;

    localparam logic [OP_W-1:0] OP_LOOP_BEGIN = 3'd0;
    localparam logic [OP_W-1:0] OP_LOOP_END   = 3'd1;
    localparam logic [OP_W-1:0] OP_CALL_BEGIN = 3'd2;
    localparam logic [OP_W-1:0] OP_CALL_END   = 3'd3;
    localparam logic [OP_W-1:0] OP_DISABLE    = 3'd4;
    localparam logic [OP_W-1:0] OP_ENABLE     = 3'd5;
    localparam logic [OP_W-1:0] OP_READ       = 3'd6;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_UPD   = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

endpackage

// ----- rtl/context_region_time_profiler.sv -----
// per-context time profiler: table read-modify-write around two context memories
//
// Usage: events enter on the s_ channel (tuser = op, tdata = offset, timestamp,
// read index); one result per event leaves on the m_ channel. The register
// context_count is written through cfg_we/cfg_wdata; the user is to write it
// only while the block is idle, which the block itself does not enforce.
// Each event is taken in the idle state, reads its context entry from the
// accumulated-ticks and start-stamp memories, and is written back in the
// update state. A loop end or call end with a nonzero offset, while tracking
// is enabled, returns the entry of the context it moves back to; the single
// read port per memory makes this a second read of the accumulated-ticks
// memory, issued at the write-back. The result register loads at the
// write-back edge, or after it in the second-read state. The result sits in
// an output register; the next event is accepted while it waits, and the
// block holds in its update or second-read state until the register is free.
// After reset a clearing pass zeroes every entry of both memories, one entry
// per cycle; no event is accepted meanwhile (config writes are).
module context_region_time_profiler #(
    parameter int MAX_CONTEXTS = 1024,
    parameter int TIME_BITS    = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [crtp_pkg::COUNT_W-1:0]    cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // context_offset[19:0], timestamp[83:20], read_index[93:84], zero pad
    input  logic [crtp_pkg::S_DATA_W-1:0]   s_tdata,
    // op[2:0]
    input  logic [crtp_pkg::OP_W-1:0]       s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // current_context[31:0], context_hit[32], context_time[96:33],
    // loop_region_time[160:97], loop_depth[176:161], tracking_disabled[177],
    // recursion_seen[178], zero pad
    output logic [crtp_pkg::M_DATA_W-1:0]   m_tdata
);

    localparam int AW = (MAX_CONTEXTS > 1) ? $clog2(MAX_CONTEXTS) : 1;
    localparam int CW = crtp_pkg::CTX_W;
    localparam int DW = crtp_pkg::DEPTH_W;

    function automatic logic tracked_f(input logic [CW-1:0] id,
                                       input logic [crtp_pkg::COUNT_W-1:0] cnt);
        return (id < CW'(cnt)) && (id < CW'(MAX_CONTEXTS));
    endfunction

    crtp_pkg::state_t state_reg, state_next;
    logic [AW-1:0]                 clr_cnt_reg;
    logic [crtp_pkg::COUNT_W-1:0]  ctx_count_reg;
    logic [CW-1:0]                 ctx_id_reg;
    logic [DW-1:0]                 depth_reg, depth_next;
    logic [DW-1:0]                 dis_cnt_reg, dis_cnt_next;
    logic [TIME_BITS-1:0]          region_reg, region_next;
    logic [TIME_BITS-1:0]          last_mark_reg, last_mark_next;

    // item registers
    logic [crtp_pkg::OP_W-1:0]     op_reg;
    logic [TIME_BITS-1:0]          now_reg;
    logic [TIME_BITS-1:0]          delta_reg;
    logic [CW-1:0]                 new_id_reg;
    logic [AW-1:0]                 upd_addr_reg;
    logic [AW-1:0]                 sec_addr_reg;
    logic                          upd_trk_reg;
    logic                          hit_reg;
    logic                          active_reg;
    logic                          off_nz_reg;
    logic                          second_reg;

    // memories
    logic [TIME_BITS-1:0] acc_mem   [MAX_CONTEXTS];
    logic [TIME_BITS-1:0] stamp_mem [MAX_CONTEXTS];
    logic [TIME_BITS-1:0] acc_rd_reg;
    logic [TIME_BITS-1:0] stamp_rd_reg;

    // output register
    logic                 m_valid_reg;
    logic [CW-1:0]        o_ctx_reg;
    logic                 o_hit_reg;
    logic [TIME_BITS-1:0] o_time_reg;
    logic [TIME_BITS-1:0] o_region_reg;
    logic [DW-1:0]        o_depth_reg;
    logic                 o_dis_reg;
    logic                 o_recur_reg;

    // accept side
    logic                           accept;
    logic [crtp_pkg::OP_W-1:0]      in_op;
    logic [crtp_pkg::OFFSET_W-1:0]  in_off;
    logic [TIME_BITS-1:0]           in_now;
    logic [crtp_pkg::RIDX_W-1:0]    in_ridx;
    logic                           in_active, in_off_nz, in_begin, in_end, in_read;
    logic [CW-1:0]                  id_plus, id_minus, upd_id, new_id, out_id;
    logic [AW-1:0]                  first_addr;

    // update side
    logic                 out_free, upd_go, out_load, clearing;
    logic                 upd_we, recur;
    logic [TIME_BITS-1:0] acc_wd, stamp_wd;
    logic                 acc_re;
    logic [AW-1:0]        acc_ra, wr_addr;
    logic                 mem_we;
    logic [TIME_BITS-1:0] acc_wr_data, stamp_wr_data;

    assign clearing = (state_reg == crtp_pkg::ST_CLEAR);
    assign s_tready = (state_reg == crtp_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign in_op   = s_tuser;
    assign in_off  = s_tdata[19:0];
    assign in_now  = s_tdata[20 +: TIME_BITS];
    assign in_ridx = s_tdata[93:84];

    always_comb begin
        in_active = (dis_cnt_reg == '0);
        in_off_nz = (in_off != '0);
        in_read   = (in_op == crtp_pkg::OP_READ);
        in_begin  = (in_op == crtp_pkg::OP_LOOP_BEGIN) ||
                    ((in_op == crtp_pkg::OP_CALL_BEGIN) && in_off_nz);
        in_end    = (in_op == crtp_pkg::OP_LOOP_END) ||
                    ((in_op == crtp_pkg::OP_CALL_END) && in_off_nz);
        id_plus   = ctx_id_reg + CW'(in_off);
        id_minus  = ctx_id_reg - CW'(in_off);
        upd_id    = (in_active && in_begin) ? id_plus : ctx_id_reg;
        if (in_active && in_begin) begin
            new_id = id_plus;
        end else if (in_active && in_end) begin
            new_id = id_minus;
        end else begin
            new_id = ctx_id_reg;
        end
        out_id     = in_read ? CW'(in_ridx) : new_id;
        first_addr = in_read ? AW'(in_ridx) : upd_id[AW-1:0];
    end

    // read-modify-write of the addressed entry, plus loop region, depth and disable count updates
    always_comb begin
        acc_wd         = acc_rd_reg;
        stamp_wd       = stamp_rd_reg;
        upd_we         = 1'b0;
        recur          = 1'b0;
        region_next    = region_reg;
        last_mark_next = last_mark_reg;
        depth_next     = depth_reg;
        dis_cnt_next   = dis_cnt_reg;
        case (op_reg)
            crtp_pkg::OP_LOOP_BEGIN: begin
                if (active_reg && upd_trk_reg) begin
                    upd_we   = 1'b1;
                    stamp_wd = now_reg;
                    if (depth_reg != '0) begin
                        region_next = region_reg + delta_reg;
                    end
                    last_mark_next = now_reg;
                    depth_next     = depth_reg + DW'(1);
                end
            end
            crtp_pkg::OP_LOOP_END: begin
                if (active_reg && upd_trk_reg) begin
                    upd_we         = 1'b1;
                    acc_wd         = acc_rd_reg + (now_reg - stamp_rd_reg);
                    stamp_wd       = '0;
                    region_next    = region_reg + delta_reg;
                    last_mark_next = now_reg;
                    depth_next     = depth_reg - DW'(1);
                end
            end
            crtp_pkg::OP_CALL_BEGIN: begin
                if (active_reg && off_nz_reg && upd_trk_reg) begin
                    upd_we = 1'b1;
                    if (stamp_rd_reg == '0) begin
                        stamp_wd = now_reg;
                    end else begin
                        acc_wd = acc_rd_reg + TIME_BITS'(1);
                        recur  = 1'b1;
                    end
                end
            end
            crtp_pkg::OP_CALL_END: begin
                if (active_reg && off_nz_reg && upd_trk_reg && (stamp_rd_reg != '0)) begin
                    upd_we   = 1'b1;
                    acc_wd   = acc_rd_reg + (now_reg - stamp_rd_reg);
                    stamp_wd = '0;
                end
            end
            crtp_pkg::OP_DISABLE: begin
                dis_cnt_next = dis_cnt_reg + DW'(1);
            end
            crtp_pkg::OP_ENABLE: begin
                dis_cnt_next = dis_cnt_reg - DW'(1);
            end
            default: begin
            end
        endcase
    end

    assign out_free = !m_valid_reg || m_tready;
    // an end event moving back commits at once and reports from the second read
    assign upd_go   = (state_reg == crtp_pkg::ST_UPD) && (second_reg || out_free);
    assign out_load = ((state_reg == crtp_pkg::ST_UPD) && !second_reg && out_free) ||
                      ((state_reg == crtp_pkg::ST_OUT) && out_free);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            crtp_pkg::ST_CLEAR: begin
                if (clr_cnt_reg == AW'(MAX_CONTEXTS - 1)) begin
                    state_next = crtp_pkg::ST_IDLE;
                end
            end
            crtp_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = crtp_pkg::ST_UPD;
                end
            end
            crtp_pkg::ST_UPD: begin
                if (upd_go) begin
                    state_next = second_reg ? crtp_pkg::ST_OUT : crtp_pkg::ST_IDLE;
                end
            end
            crtp_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = crtp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = crtp_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        mem_we        = clearing || (upd_go && upd_we);
        wr_addr       = clearing ? clr_cnt_reg : upd_addr_reg;
        acc_wr_data   = clearing ? '0 : acc_wd;
        stamp_wr_data = clearing ? '0 : stamp_wd;
        acc_re        = accept || (upd_go && second_reg);
        acc_ra        = accept ? first_addr : sec_addr_reg;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            acc_mem[wr_addr] <= acc_wr_data;
        end
        if (acc_re) begin
            acc_rd_reg <= acc_mem[acc_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stamp_mem[wr_addr] <= stamp_wr_data;
        end
        if (accept) begin
            stamp_rd_reg <= stamp_mem[first_addr];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= crtp_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            ctx_count_reg <= '0;
            ctx_id_reg    <= '0;
            depth_reg     <= '0;
            dis_cnt_reg   <= '0;
            region_reg    <= '0;
            last_mark_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (clearing) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cfg_we) begin
                ctx_count_reg <= cfg_wdata;
            end
            if (upd_go) begin
                ctx_id_reg    <= new_id_reg;
                depth_reg     <= depth_next;
                dis_cnt_reg   <= dis_cnt_next;
                region_reg    <= region_next;
                last_mark_reg <= last_mark_next;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // item capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg       <= in_op;
            now_reg      <= in_now;
            delta_reg    <= in_now - last_mark_reg;
            new_id_reg   <= new_id;
            upd_addr_reg <= upd_id[AW-1:0];
            sec_addr_reg <= new_id[AW-1:0];
            upd_trk_reg  <= tracked_f(upd_id, ctx_count_reg);
            hit_reg      <= tracked_f(out_id, ctx_count_reg);
            active_reg   <= in_active;
            off_nz_reg   <= in_off_nz;
            second_reg   <= in_active && in_end && in_off_nz;
        end
    end

    // result capture
    always_ff @(posedge aclk) begin
        if (out_load) begin
            o_hit_reg <= hit_reg;
            if (state_reg == crtp_pkg::ST_OUT) begin
                o_ctx_reg    <= ctx_id_reg;
                o_time_reg   <= hit_reg ? acc_rd_reg : '0;
                o_region_reg <= region_reg;
                o_depth_reg  <= depth_reg;
                o_dis_reg    <= (dis_cnt_reg != '0);
                o_recur_reg  <= 1'b0;
            end else begin
                o_ctx_reg    <= new_id_reg;
                o_time_reg   <= hit_reg ? acc_wd : '0;
                o_region_reg <= region_next;
                o_depth_reg  <= depth_next;
                o_dis_reg    <= (dis_cnt_next != '0);
                o_recur_reg  <= recur;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, o_recur_reg, o_dis_reg, o_depth_reg,
                       64'(o_region_reg), 64'(o_time_reg), o_hit_reg, o_ctx_reg};

`ifndef SYNTH
    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg != crtp_pkg::ST_IDLE))
        else $error("context memory written while idle");

    a_out_after_upd: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == crtp_pkg::ST_OUT) |->
            ($past(state_reg) == crtp_pkg::ST_UPD || $past(state_reg) == crtp_pkg::ST_OUT))
        else $error("second read state entered without an update");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |->
            ($past(state_reg) == crtp_pkg::ST_UPD || $past(state_reg) == crtp_pkg::ST_OUT))
        else $error("result produced outside update or second read");
`endif

endmodule
